// ===== src/irdsf_pkg.sv =====
// ----------------------------------------------------------------------------
// irdsf_pkg
// Shared types, constants and threshold helpers for the IR distance
// staircase filter.
// ----------------------------------------------------------------------------
`default_nettype none

package irdsf_pkg;

    // Converter sample width used for the staircase; the field itself is
    // CODE_FIELD_BITS wide and only its low SAMPLE_BITS bits are used.
    localparam int SAMPLE_BITS     = 12;
    localparam int CODE_FIELD_BITS = 12;
    localparam int FULL_SCALE      = (1 << SAMPLE_BITS) - 1;

    localparam int HALF_BITS   = 8;
    localparam int SMOOTH_BITS = 15;
    localparam int GAIN_BITS   = 17;
    localparam int NUM_STEPS   = 30;

    typedef logic [SAMPLE_BITS-1:0]     code_t;
    typedef logic [CODE_FIELD_BITS-1:0] code_field_t;
    typedef logic [HALF_BITS-1:0]       half_t;
    typedef logic [SMOOTH_BITS-1:0]     smooth_t;
    typedef logic [GAIN_BITS-1:0]       gain_t;

    localparam gain_t   GAIN_ONE     = 17'd65536;
    localparam gain_t   GAIN_RESET   = 17'd32768;
    localparam smooth_t SMOOTH_RESET = 15'd25600;
    localparam half_t   OUT_OF_RANGE = 8'd200;
    localparam half_t   LAST_STEP    = 8'd62;
    localparam half_t   NEAREST_STEP = 8'd10;

    // Threshold for a voltage of at least 'tenths' tenths of a volt:
    // ceil(tenths / 33 * FULL_SCALE).
    function automatic code_t step_threshold(input int tenths);
        return code_t'((tenths * FULL_SCALE + 32) / 33);
    endfunction

    // 0.05 V threshold: ceil(FULL_SCALE / 66).
    localparam code_t LAST_THRESHOLD = code_t'((FULL_SCALE + 65) / 66);

    // Distance in half cm for step idx (idx 0 is 3.0 V, idx 29 is 0.1 V).
    function automatic half_t step_half_cm(input int idx);
        half_t d;
        case (idx)
            0:       d = 8'd10;
            1:       d = 8'd12;
            2:       d = 8'd14;
            3:       d = 8'd16;
            4:       d = 8'd18;
            5:       d = 8'd20;
            6:       d = 8'd22;
            7:       d = 8'd24;
            8:       d = 8'd26;
            9:       d = 8'd28;
            10:      d = 8'd30;
            11:      d = 8'd32;
            12:      d = 8'd34;
            13:      d = 8'd36;
            14:      d = 8'd38;
            15:      d = 8'd40;
            16:      d = 8'd42;
            17:      d = 8'd44;
            18:      d = 8'd46;
            19:      d = 8'd48;
            20:      d = 8'd50;
            21:      d = 8'd51;
            22:      d = 8'd52;
            23:      d = 8'd53;
            24:      d = 8'd54;
            25:      d = 8'd55;
            26:      d = 8'd56;
            27:      d = 8'd57;
            28:      d = 8'd58;
            29:      d = 8'd60;
            default: d = OUT_OF_RANGE;
        endcase
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== src/irdsf_sample_if.sv =====
// ----------------------------------------------------------------------------
// irdsf_sample_if
// Valid/ready channel carrying one converter sample per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface irdsf_sample_if;
    logic                       valid;
    logic                       ready;
    irdsf_pkg::code_field_t     sensor_code;

    modport source (output valid, output sensor_code, input ready);
    modport sink   (input valid, input sensor_code, output ready);
endinterface

`default_nettype wire

// ===== src/irdsf_result_if.sv =====
// ----------------------------------------------------------------------------
// irdsf_result_if
// Valid/ready channel carrying raw and smoothed distance per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface irdsf_result_if;
    logic                   valid;
    logic                   ready;
    irdsf_pkg::half_t       raw_distance_half_cm;
    irdsf_pkg::smooth_t     smoothed_distance;

    modport source (output valid, output raw_distance_half_cm,
                    output smoothed_distance, input ready);
    modport sink   (input valid, input raw_distance_half_cm,
                    input smoothed_distance, output ready);
endinterface

`default_nettype wire

// ===== src/irdsf_staircase.sv =====
// ----------------------------------------------------------------------------
// irdsf_staircase
// Comparator ladder mapping a converter sample to a distance in half cm.
// ----------------------------------------------------------------------------
`default_nettype none

module irdsf_staircase (
    input  wire irdsf_pkg::code_t code,
    output irdsf_pkg::half_t      half_cm
);

    always_comb
    begin
        half_cm = irdsf_pkg::OUT_OF_RANGE;
        if (code >= irdsf_pkg::LAST_THRESHOLD)
        begin
            half_cm = irdsf_pkg::LAST_STEP;
        end
        // Walk from the lowest threshold up so the highest match wins;
        // a sample equal to a threshold takes the shorter distance.
        for (int i = irdsf_pkg::NUM_STEPS - 1; i >= 0; i--)
        begin
            if (code >= irdsf_pkg::step_threshold(irdsf_pkg::NUM_STEPS - i))
            begin
                half_cm = irdsf_pkg::step_half_cm(i);
            end
        end
    end

endmodule

`default_nettype wire

// ===== src/ir_distance_staircase_filter.sv =====
// ----------------------------------------------------------------------------
// ir_distance_staircase_filter
// IR sensor sample to distance staircase, followed by an exponential filter.
//
// Usage:
//   sample : sink channel, one converter code per transfer.
//   result : source channel, raw staircase distance (half cm) and filtered
//            distance (1/256 cm), one result per accepted sample.
//   cfg_we / cfg_data : writes the Q16 smoothing gain (values above 1.0
//            act as 1.0). Write only while no sample is in flight.
// Result valid rises once a sample has passed the sample register and the
// result register. The block takes one sample per cycle unless result is
// stalled: the comparator ladder sits in front of the sample register, and
// the single 18x16 multiply-add of the filter sits between that register and
// the result register, which also holds the filter state.
// When result is stalled, one more sample is held in the sample register,
// after which sample.ready drops until the result is taken.
// Reset empties both stages, sets the gain to 0.5 and the filter state
// to 100 cm.
// ----------------------------------------------------------------------------
`default_nettype none

module ir_distance_staircase_filter (
    input  wire                     clk,
    input  wire                     rst_n,
    irdsf_sample_if.sink            sample,
    irdsf_result_if.source          result,
    input  wire                     cfg_we,
    input  wire irdsf_pkg::gain_t   cfg_data
);

    irdsf_pkg::gain_t   gain_reg;
    logic               a_valid_reg;
    irdsf_pkg::half_t   a_half_reg;
    logic               r_valid_reg;
    irdsf_pkg::half_t   raw_reg;
    irdsf_pkg::smooth_t smooth_reg;

    irdsf_pkg::half_t   stair_half;
    irdsf_pkg::gain_t   gain_sat;
    irdsf_pkg::smooth_t target;
    logic signed [15:0] diff_s;
    logic signed [33:0] prod;
    irdsf_pkg::smooth_t smooth_next;
    logic               sample_xfer;
    logic               advance;

    irdsf_staircase u_stair (
        .code    (sample.sensor_code[irdsf_pkg::SAMPLE_BITS-1:0]),
        .half_cm (stair_half)
    );

    assign advance      = a_valid_reg && (!r_valid_reg || result.ready);
    assign sample.ready = !a_valid_reg || !r_valid_reg || result.ready;
    assign sample_xfer  = sample.valid && sample.ready;

    // prev + floor(gain * (target - prev) / 65536)
    assign gain_sat    = (gain_reg > irdsf_pkg::GAIN_ONE) ? irdsf_pkg::GAIN_ONE : gain_reg;
    assign target      = {a_half_reg, 7'b0};
    assign diff_s      = $signed({1'b0, target}) - $signed({1'b0, smooth_reg});
    assign prod        = $signed({1'b0, gain_sat}) * diff_s;
    assign smooth_next = smooth_reg + prod[30:16];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= irdsf_pkg::GAIN_RESET;
        end
        else if (cfg_we)
        begin
            gain_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (sample_xfer)
        begin
            a_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_xfer)
        begin
            a_half_reg <= stair_half;
        end
    end

    // The result register doubles as filter memory: update only on advance.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            smooth_reg  <= irdsf_pkg::SMOOTH_RESET;
        end
        else if (advance)
        begin
            r_valid_reg <= 1'b1;
            smooth_reg  <= smooth_next;
        end
        else if (result.ready)
        begin
            r_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            raw_reg <= a_half_reg;
        end
    end

    assign result.valid                = r_valid_reg;
    assign result.raw_distance_half_cm = raw_reg;
    assign result.smoothed_distance    = smooth_reg;

    // Filter state is a convex mix of distances, so it stays within 100 cm.
    a_smooth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        smooth_reg <= irdsf_pkg::SMOOTH_RESET)
        else $error("filter state above 100 cm");

    a_raw_range: assert property (@(posedge clk) disable iff (!rst_n)
        r_valid_reg |-> (raw_reg == irdsf_pkg::OUT_OF_RANGE) ||
                        ((raw_reg >= irdsf_pkg::NEAREST_STEP) &&
                         (raw_reg <= irdsf_pkg::LAST_STEP)))
        else $error("raw distance outside staircase");

    a_full_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg_we && gain_reg >= irdsf_pkg::GAIN_ONE) |=>
            (smooth_reg == {raw_reg, 7'b0}))
        else $error("unit gain must track raw distance");

    a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !cfg_we && gain_reg == '0) |=> $stable(smooth_reg))
        else $error("zero gain must hold filter state");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        !sample.ready |-> (a_valid_reg && r_valid_reg && !result.ready))
        else $error("sample stalled with room in pipeline");

endmodule

`default_nettype wire
